// ===== hw/rtl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the Taylor sine block
// Fixed-point widths, register map and the beat passed between term steps.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Q28 fixed point throughout
  localparam int FRAC_W   = 28;
  localparam int ANGLE_W  = 32;
  localparam int OUT_W    = 36;

  // Internal widths. |x| < 8.0 bounds every term below 2^9 and the
  // partial sum below 2^11 in real units, so none of these can wrap.
  localparam int TERM_W   = 40;
  localparam int NSQ_W    = 36;
  localparam int SUM_W    = 44;
  localparam int P1_W     = 48;
  localparam int RECIP_W  = 27;

  // Operand splits for the partial-product multipliers
  localparam int T_LO_W   = 20;
  localparam int P1_LO_W  = 24;

  // Configuration
  localparam int HTI_W    = 4;
  localparam logic [HTI_W-1:0] HTI_RESET = 4'd5;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_HTI = 1'b0;

  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic signed [NSQ_W-1:0]  nsq;
    logic signed [SUM_W-1:0]  sum;
  } sts_beat_t;

endpackage

// ===== hw/rtl/sts_if.sv =====
// ----------------------------------------------------------------------------
// sts_if: stream channels of the Taylor sine block
// Angle input channel and sum output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sts_angle_if;
  logic                                valid;
  logic                                ready;
  logic signed [sts_pkg::ANGLE_W-1:0]  angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface sts_sum_if;
  logic                              valid;
  logic                              ready;
  logic signed [sts_pkg::OUT_W-1:0]  sine_sum;

  modport source (output valid, output sine_sum, input ready);
  modport sink   (input valid, input sine_sum, output ready);
endinterface

// ===== hw/rtl/sine_taylor_series.sv =====
// ----------------------------------------------------------------------------
// sine_taylor_series: truncated Taylor sum of sin(x) in Q28
// Fully pipelined, a step per term but the last, saturated 36-bit result.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                 handshake
//  --------  ---  ----------------------  ----------------------------
//  in_i      in   angle    s32  Q28       valid/ready
//  out_o     out  sine_sum s36  Q28       valid/ready
//  APB       in   highest_term_index u4   psel/penable/pwrite, addr 0
//
//  One beat per cycle in and out unless the output stalls. An angle is
//  registered after x*x, after forming -x*x and term 0, after each of the
//  two split multiplies and each recombine add of every term step, after
//  the final add and in the output register.
//  Reset clears valid bits, the output and skid flags and sets the term
//  index to 5; data registers are not reset.
//  A stalled output keeps one result in the output register and one in the
//  skid; the pipeline only freezes while the skid is full and the last stage
//  holds a beat, so input ready comes from registers alone.
//
module sine_taylor_series #(
  parameter int MAX_TERMS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sts_angle_if.sink                     in_i,
  sts_sum_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sts_pkg::APB_AW-1:0]    paddr,
  input  logic [sts_pkg::APB_DW-1:0]    pwdata,
  output logic [sts_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import sts_pkg::*;

  localparam int LastK = MAX_TERMS - 1;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [HTI_W-1:0] hti_q;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_HTI);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hti_q <= HTI_RESET;
    end else if (cfg_wr) begin
      hti_q <= pwdata[HTI_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = APB_DW'(hti_q);

  // --------------------------------------------------------------------------
  // Pipeline advance: frozen only when skid full and last stage occupied
  // --------------------------------------------------------------------------
  logic en;
  logic vf_q;
  logic skid_valid_q, skid_valid_d;

  assign en       = !skid_valid_q || !vf_q;
  assign in_i.ready = en;

  // --------------------------------------------------------------------------
  // Front end: x*x, then -(x*x >>> 28) and term 0 = x
  // --------------------------------------------------------------------------
  logic                        va_q, vb_q;
  logic signed [ANGLE_W-1:0]   xa_q;
  logic signed [2*ANGLE_W-1:0] sq_q, sq_d;
  sts_beat_t                   beat0_q, beat0_d;

  assign sq_d = in_i.angle * in_i.angle;

  always_comb begin
    // x*x is never negative and at most 2^62, so the top bit is clear
    beat0_d.term = TERM_W'(xa_q);
    beat0_d.nsq  = -$signed(sq_q[FRAC_W +: NSQ_W]);
    beat0_d.sum  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= in_i.valid;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_q    <= in_i.angle;
      sq_q    <= sq_d;
      beat0_q <= beat0_d;
    end
  end

  // --------------------------------------------------------------------------
  // Term steps: step k adds term k (when k <= n) and forms term k+1
  // --------------------------------------------------------------------------
  sts_beat_t            beat [MAX_TERMS];
  logic [MAX_TERMS-1:0] vld;

  assign beat[0] = beat0_q;
  assign vld[0]  = vb_q;

  for (genvar k = 0; k < MAX_TERMS - 1; k++) begin : g_step
    // R(k) = round(2^28 / ((2k+2)(2k+3))), halves up
    localparam longint unsigned Den = longint'((2*k + 2) * (2*k + 3));
    localparam longint unsigned RecipVal = ((64'd1 << FRAC_W) + Den / 2) / Den;
    localparam logic signed [RECIP_W-1:0] Recip = RECIP_W'(RecipVal);

    logic add_term;
    assign add_term = (k <= int'(hti_q));

    sts_step u_step (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .valid_i    (vld[k]),
      .add_term_i (add_term),
      .recip_i    (Recip),
      .beat_i     (beat[k]),
      .valid_o    (vld[k+1]),
      .beat_o     (beat[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Final add of the last term
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sumf_q, sumf_d;
  logic                    add_last;

  assign add_last = (LastK <= int'(hti_q));
  assign sumf_d   = add_last ? beat[LastK].sum + SUM_W'(beat[LastK].term)
                             : beat[LastK].sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en) begin
      vf_q <= vld[LastK];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sumf_q <= sumf_d;
    end
  end

  // --------------------------------------------------------------------------
  // Saturate to 36 bits
  // --------------------------------------------------------------------------
  localparam logic signed [OUT_W-1:0] OutMax = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OutMin = {1'b1, {(OUT_W-1){1'b0}}};

  logic signed [OUT_W-1:0]   sat;
  logic [SUM_W-OUT_W:0]      sum_top;

  always_comb begin
    sum_top = sumf_q[SUM_W-1:OUT_W-1];
    if ((sum_top == '0) || (sum_top == '1)) begin
      sat = sumf_q[OUT_W-1:0];
    end else if (sumf_q[SUM_W-1]) begin
      sat = OutMin;
    end else begin
      sat = OutMax;
    end
  end

  // --------------------------------------------------------------------------
  // Output register plus one-entry skid
  // --------------------------------------------------------------------------
  logic                    out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0] out_q, out_d, skid_q, skid_d;
  logic                    pop, push;

  assign pop  = out_valid_q && out_o.ready;
  assign push = en && vf_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // no push can arrive while the skid is full
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_d       = sat;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = sat;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.sine_sum = out_q;

endmodule

// ===== hw/rtl/sts_step.sv =====
// ----------------------------------------------------------------------------
// sts_step: one term of the series, four register stages
// Adds the term to the sum when add_term_i is set and forms the next term:
// ((term * nsq) >>> 28) * recip >>> 28, each product split in two halves.
// ----------------------------------------------------------------------------
module sts_step (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic                                 add_term_i,
  input  logic signed [sts_pkg::RECIP_W-1:0]   recip_i,
  input  sts_pkg::sts_beat_t                   beat_i,
  output logic                                 valid_o,
  output sts_pkg::sts_beat_t                   beat_o
);
  import sts_pkg::*;

  localparam int PA_W  = TERM_W - T_LO_W + NSQ_W;
  localparam int PB_W  = T_LO_W + 1 + NSQ_W;
  localparam int PR1_W = TERM_W + NSQ_W;
  localparam int QA_W  = P1_W - P1_LO_W + RECIP_W;
  localparam int QB_W  = P1_LO_W + 1 + RECIP_W;
  localparam int PR2_W = P1_W + RECIP_W;

  logic [3:0] v_q;

  logic signed [PA_W-1:0]   pa_q, pa_d;
  logic signed [PB_W-1:0]   pb_q, pb_d;
  logic signed [P1_W-1:0]   p1_q, p1_d;
  logic signed [QA_W-1:0]   qa_q, qa_d;
  logic signed [QB_W-1:0]   qb_q, qb_d;
  logic signed [NSQ_W-1:0]  nsq1_q, nsq2_q, nsq3_q;
  logic signed [SUM_W-1:0]  sum1_q, sum2_q, sum3_q, sum1_d;
  sts_beat_t                beat_q, beat_d;

  logic signed [TERM_W-T_LO_W-1:0] t_hi;
  logic signed [T_LO_W:0]          t_lo;
  logic signed [P1_W-P1_LO_W-1:0]  p_hi;
  logic signed [P1_LO_W:0]         p_lo;
  logic signed [PR1_W-1:0]         prod1;
  logic signed [PR2_W-1:0]         prod2;

  // stage 1: partial products of term * nsq, sum update
  always_comb begin
    t_hi   = $signed(beat_i.term[TERM_W-1:T_LO_W]);
    t_lo   = $signed({1'b0, beat_i.term[T_LO_W-1:0]});
    pa_d   = t_hi * beat_i.nsq;
    pb_d   = t_lo * beat_i.nsq;
    sum1_d = add_term_i ? beat_i.sum + SUM_W'(beat_i.term) : beat_i.sum;
  end

  // stage 2: recombine, floor shift
  always_comb begin
    prod1 = (PR1_W'(pa_q) <<< T_LO_W) + PR1_W'(pb_q);
    p1_d  = prod1[FRAC_W +: P1_W];
  end

  // stage 3: partial products of p1 * recip
  always_comb begin
    p_hi = $signed(p1_q[P1_W-1:P1_LO_W]);
    p_lo = $signed({1'b0, p1_q[P1_LO_W-1:0]});
    qa_d = p_hi * recip_i;
    qb_d = p_lo * recip_i;
  end

  // stage 4: recombine into the next term
  always_comb begin
    prod2       = (PR2_W'(qa_q) <<< P1_LO_W) + PR2_W'(qb_q);
    beat_d.term = prod2[FRAC_W +: TERM_W];
    beat_d.nsq  = nsq3_q;
    beat_d.sum  = sum3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      nsq1_q <= beat_i.nsq;
      sum1_q <= sum1_d;
      p1_q   <= p1_d;
      nsq2_q <= nsq1_q;
      sum2_q <= sum1_q;
      qa_q   <= qa_d;
      qb_q   <= qb_d;
      nsq3_q <= nsq2_q;
      sum3_q <= sum2_q;
      beat_q <= beat_d;
    end
  end

  assign valid_o = v_q[3];
  assign beat_o  = beat_q;

endmodule

// ===== hw/rtl/sts_checker.sv =====
// ----------------------------------------------------------------------------
// sts_checker: port-level checks of the Taylor sine block
// Output stall hold, no result without a pending beat, readback, reset value.
// ----------------------------------------------------------------------------
module sts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sts_pkg::OUT_W-1:0]     out_sum,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [sts_pkg::APB_AW-1:0]    paddr,
  input logic [sts_pkg::APB_DW-1:0]    pwdata,
  input logic [sts_pkg::APB_DW-1:0]    prdata
);
  import sts_pkg::*;

  logic [15:0] pending_q;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 16'(in_acc) - 16'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_sum))
    else $error("result changed or dropped while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != '0)
    else $error("result beat without a pending angle beat");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_HTI)
    |=> prdata == APB_DW'($past(pwdata[HTI_W-1:0])))
    else $error("term index readback mismatch");

  a_reset_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> prdata == APB_DW'(HTI_RESET))
    else $error("term index not at reset value");

endmodule

bind sine_taylor_series sts_checker u_sts_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_sum   (out_o.sine_sum),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
